@@ hw/rtl/pfdq_pkg.sv @@
package pfdq_pkg;

    localparam int BUF_W   = 38;
    localparam int CNT_W   = 6;
    localparam int CODE_W  = 31;
    localparam int VAL_W   = 32;
    localparam int SEEN_W  = 25;
    localparam int ITEM_W  = 24;
    localparam int SIZE_W  = 5;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;
    localparam int PROD_W  = CODE_W + VAL_W;
    localparam int QUO_W   = 32;
    localparam int STEPS   = QUO_W / 2;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int RES_W   = 4;
    localparam int MAX_RES = 8;

    localparam logic [IDX_W-1:0] REG_BIT_SIZE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_RANGE_Q    = 3'd1;
    localparam logic [IDX_W-1:0] REG_START_Q    = 3'd2;
    localparam logic [IDX_W-1:0] REG_SKIP_ITEMS = 3'd3;
    localparam logic [IDX_W-1:0] REG_ITEM_COUNT = 3'd4;

    localparam logic [SIZE_W-1:0] BIT_SIZE_RESET = 5'd8;
    localparam logic [CFG_W-1:0]  RANGE_Q_RESET  = 32'h0001_0000;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic extract;
        logic div_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic drop;
        logic can_extract;
        logic emit;
        logic div_busy;
        logic out_free;
    } status_t;

endpackage

@@ hw/rtl/packed_float_dequantizer_core.sv @@
// Takes one byte per accept; a byte that is dropped frees the input again in the next cycle.
// A byte that is kept is scanned code by code; each emitted code passes the MUL, DIV and OUT states,
// where DIV waits on the radix-4 divider; up to eight codes are emitted per byte.
// A result word waits in the output register while the next byte is accepted.
// Reset is asynchronous and active low; it loads the register defaults and empties the buffer.
module packed_float_dequantizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // stream_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // raw_code[30:0], value_q[62:31], zero[63]
    output logic        m_axis_tlast    // last_code
);
    import pfdq_pkg::*;

    cmd_t              cmd;
    status_t           status;
    logic [CODE_W-1:0] raw_code;
    logic [VAL_W-1:0]  value_q;

    pfdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pfdq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .data_byte    (s_axis_tdata),
        .stream_start (s_axis_tuser),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .raw_code     (raw_code),
        .value_q      (value_q),
        .last_code    (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, value_q, raw_code};

endmodule

@@ hw/rtl/pfdq_div.sv @@
module pfdq_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pfdq_pkg::PROD_W-1:0]    dividend,
    input  logic [pfdq_pkg::CODE_W-1:0]    divisor,
    output logic [pfdq_pkg::QUO_W-1:0]     quotient,
    output logic                           busy
);
    import pfdq_pkg::*;

    logic [CODE_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0]  dvd_reg, dvd_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [CODE_W-1:0] den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;

    logic [CODE_W+1:0] part;
    logic [CODE_W+1:0] d1;
    logic [CODE_W+1:0] d2;
    logic [CODE_W+1:0] d3;
    logic [1:0]        digit;
    logic [CODE_W+1:0] diff;

    always_comb
    begin
        part = {rem_reg, dvd_reg[QUO_W-1 -: 2]};
        d1   = {2'b00, den_reg};
        d2   = {1'b0, den_reg, 1'b0};
        d3   = d1 + d2;
        if (part >= d3)
        begin
            digit = 2'd3;
            diff  = part - d3;
        end
        else if (part >= d2)
        begin
            digit = 2'd2;
            diff  = part - d2;
        end
        else if (part >= d1)
        begin
            digit = 2'd1;
            diff  = part - d1;
        end
        else
        begin
            digit = 2'd0;
            diff  = part;
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = dividend[PROD_W-1 -: CODE_W];
            dvd_next  = dividend[QUO_W-1:0];
            den_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = diff[CODE_W-1:0];
            dvd_next  = {dvd_reg[QUO_W-3:0], 2'b00};
            quo_next  = {quo_reg[QUO_W-3:0], digit};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

@@ hw/rtl/pfdq_dp.sv @@
module pfdq_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pfdq_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pfdq_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic [7:0]                    data_byte,
    input  logic                          stream_start,
    input  pfdq_pkg::cmd_t                cmd,
    output pfdq_pkg::status_t             status,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [pfdq_pkg::CODE_W-1:0]   raw_code,
    output logic [pfdq_pkg::VAL_W-1:0]    value_q,
    output logic                          last_code
);
    import pfdq_pkg::*;

    logic [SIZE_W-1:0] bit_size_reg;
    logic [VAL_W-1:0]  range_q_reg;
    logic [VAL_W-1:0]  start_q_reg;
    logic [ITEM_W-1:0] skip_items_reg;
    logic [ITEM_W-1:0] item_count_reg;

    logic [BUF_W-1:0]  buf_reg, buf_next;
    logic [CNT_W-1:0]  bits_reg, bits_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              last_reg, last_next;

    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    logic [VAL_W-1:0]  out_value_reg;
    logic              out_last_reg;

    logic [SEEN_W-1:0] total;
    logic [SEEN_W-1:0] seen_eff;
    logic [BUF_W-1:0]  buf_eff;
    logic [CNT_W-1:0]  bits_eff;
    logic [CODE_W-1:0] mask;
    logic [CODE_W-1:0] code_now;
    logic              range_neg;
    logic [VAL_W-1:0]  mag;
    logic [PROD_W-1:0] product;
    logic [QUO_W-1:0]  quotient;
    logic              div_busy;
    logic [VAL_W-1:0]  signed_q;

    assign total    = {1'b0, skip_items_reg} + {1'b0, item_count_reg};
    assign seen_eff = stream_start ? '0 : seen_reg;
    assign buf_eff  = stream_start ? '0 : buf_reg;
    assign bits_eff = stream_start ? '0 : bits_reg;
    assign mask     = {CODE_W{1'b1}} >> (5'(CODE_W) - bit_size_reg);
    assign code_now = buf_reg[CODE_W-1:0] & mask;

    assign range_neg = range_q_reg[VAL_W-1];
    assign mag       = range_neg ? (VAL_W'(0) - range_q_reg) : range_q_reg;
    assign product   = PROD_W'(code_reg) * PROD_W'(mag);
    assign signed_q  = range_neg ? (VAL_W'(0) - quotient) : quotient;

    pfdq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (mask),
        .quotient (quotient),
        .busy     (div_busy)
    );

    always_comb
    begin
        status.drop        = (bit_size_reg == '0) || (seen_eff >= total);
        status.can_extract = ({1'b0, bit_size_reg} <= bits_reg) && (seen_reg < total);
        status.emit        = seen_reg >= {1'b0, skip_items_reg};
        status.div_busy    = div_busy;
        status.out_free    = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        buf_next  = buf_reg;
        bits_next = bits_reg;
        seen_next = seen_reg;
        code_next = code_reg;
        last_next = last_reg;
        if (cmd.accept)
        begin
            buf_next  = buf_eff;
            bits_next = bits_eff;
            seen_next = seen_eff;
            if (!status.drop)
            begin
                buf_next  = buf_eff | (BUF_W'(data_byte) << bits_eff);
                bits_next = bits_eff + CNT_W'(8);
            end
        end
        else if (cmd.extract)
        begin
            buf_next  = buf_reg >> bit_size_reg;
            bits_next = bits_reg - {1'b0, bit_size_reg};
            seen_next = seen_reg + 1'b1;
            code_next = code_now;
            last_next = (seen_reg + 1'b1) == total;
        end
        if (cfg_we && (cfg_index == REG_BIT_SIZE))
        begin
            buf_next  = '0;
            bits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_size_reg   <= BIT_SIZE_RESET;
            range_q_reg    <= RANGE_Q_RESET;
            start_q_reg    <= '0;
            skip_items_reg <= '0;
            item_count_reg <= '0;
            buf_reg        <= '0;
            bits_reg       <= '0;
            seen_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            buf_reg  <= buf_next;
            bits_reg <= bits_next;
            seen_reg <= seen_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_BIT_SIZE:   bit_size_reg   <= cfg_wdata[SIZE_W-1:0];
                    REG_RANGE_Q:    range_q_reg    <= cfg_wdata;
                    REG_START_Q:    start_q_reg    <= cfg_wdata;
                    REG_SKIP_ITEMS: skip_items_reg <= cfg_wdata[ITEM_W-1:0];
                    REG_ITEM_COUNT: item_count_reg <= cfg_wdata[ITEM_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        last_reg <= last_next;
        if (cmd.out_load)
        begin
            out_code_reg  <= code_reg;
            out_value_reg <= signed_q + start_q_reg;
            out_last_reg  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign raw_code  = out_code_reg;
    assign value_q   = out_value_reg;
    assign last_code = out_last_reg;

endmodule

@@ hw/rtl/pfdq_ctrl.sv @@
module pfdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfdq_pkg::status_t   status,
    output pfdq_pkg::cmd_t      cmd
);
    import pfdq_pkg::*;

    state_t           state_reg, state_next;
    logic [RES_W-1:0] n_reg, n_next;

    always_comb
    begin
        state_next    = state_reg;
        n_next        = n_reg;
        cmd.accept    = 1'b0;
        cmd.extract   = 1'b0;
        cmd.div_start = 1'b0;
        cmd.out_load  = 1'b0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    n_next     = '0;
                    if (!status.drop)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.can_extract && (n_reg < RES_W'(MAX_RES)))
                begin
                    cmd.extract = 1'b1;
                    if (status.emit)
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
        end
    end

endmodule
